// ===== rtl/persian_glyph_shaper_unit_macros.svh =====
// Assertion macros shared by the glyph shaper RTL.
// Needs no other file; the checks compile away when SYNTHESIS is defined.
`ifndef PERSIAN_GLYPH_SHAPER_UNIT_MACROS_SVH
`define PERSIAN_GLYPH_SHAPER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PGS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pgs assertion failed");
`define PGS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pgs forbidden condition seen");
`else
`define PGS_ASSERT(lbl, clk, rst_n, prop)
`define PGS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/pgs_pkg.sv =====
// Package for the glyph shaper: form table, non-joining set, types.
// No dependencies; used by every module of the block.
`default_nettype none

package pgs_pkg;

  localparam int NumRows    = 45;
  localparam int NumCols    = 5;
  localparam int NumNonJoin = 13;
  localparam int RowW       = $clog2(NumRows + 1);
  localparam logic [RowW-1:0] NoRow  = RowW'(NumRows);
  localparam logic [RowW-1:0] YehRow = RowW'(39);

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    FORM_BASE     = 3'd0,
    FORM_ISOLATED = 3'd1,
    FORM_INITIAL  = 3'd2,
    FORM_MEDIAL   = 3'd3,
    FORM_FINAL    = 3'd4
  } form_e;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic            persian;
    logic            nonjoin;
  } cls_t;

  typedef struct packed {
    logic [15:0] glyph;
    logic        last;
  } entry_t;

  localparam logic [15:0] FormTable [NumRows][NumCols] = '{
    '{16'h0623, 16'hFE83, 16'h0623, 16'hFE84, 16'hFE84},
    '{16'h0627, 16'hFE8D, 16'h0627, 16'hFE8E, 16'hFE8E},
    '{16'h0622, 16'hFE81, 16'h0622, 16'hFE82, 16'hFE82},
    '{16'h0621, 16'hFE80, 16'h0621, 16'h0621, 16'h0621},
    '{16'h0624, 16'hFE85, 16'h0624, 16'hFE86, 16'hFE86},
    '{16'h0625, 16'hFE87, 16'h0625, 16'hFE88, 16'hFE88},
    '{16'h0626, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A},
    '{16'h0628, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90},
    '{16'h067E, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57},
    '{16'h062A, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96},
    '{16'h0629, 16'hFE93, 16'h0629, 16'h0629, 16'hFE94},
    '{16'h062B, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A},
    '{16'h062C, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E},
    '{16'h0686, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B},
    '{16'h062D, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2},
    '{16'h062E, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6},
    '{16'h062F, 16'hFEA9, 16'h062F, 16'hFEAA, 16'hFEAA},
    '{16'h0630, 16'hFEAB, 16'h0630, 16'hFEAC, 16'hFEAC},
    '{16'h0631, 16'hFEAD, 16'h0631, 16'hFEAE, 16'hFEAE},
    '{16'h0632, 16'hFEAF, 16'h0632, 16'hFEB0, 16'hFEB0},
    '{16'h0698, 16'hFB8A, 16'h0698, 16'hFB8B, 16'hFB8B},
    '{16'h0633, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2},
    '{16'h0634, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6},
    '{16'h0635, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA},
    '{16'h0636, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE},
    '{16'h0637, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2},
    '{16'h0638, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6},
    '{16'h0639, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA},
    '{16'h063A, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE},
    '{16'h0641, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2},
    '{16'h0642, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6},
    '{16'h06A9, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
    '{16'h0643, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
    '{16'h06AF, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93},
    '{16'h0644, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE},
    '{16'h0645, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2},
    '{16'h0646, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6},
    '{16'h0647, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA},
    '{16'h0648, 16'hFEED, 16'h0648, 16'hFEEE, 16'hFEEE},
    '{16'h06CC, 16'hFBFC, 16'hFBFE, 16'hFBFF, 16'hFBFD},
    '{16'h064A, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2},
    '{16'h0649, 16'hFEEF, 16'h0649, 16'hFEF0, 16'hFEF0},
    '{16'h0640, 16'h0640, 16'h0640, 16'h0640, 16'h0640},
    '{16'hFEFB, 16'hFEFB, 16'hFEFB, 16'hFEFC, 16'hFEFC},
    '{16'hFEF7, 16'hFEF7, 16'hFEF7, 16'hFEF8, 16'hFEF8}
  };

  // Persian yeh is drawn with the Arabic yeh / alef maksura forms
  localparam logic [15:0] YehSub [NumCols] = '{
    16'h06CC, 16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0
  };

  localparam logic [15:0] NonJoinSet [NumNonJoin] = '{
    16'h0621, 16'h0622, 16'h0623, 16'h0624, 16'h0625, 16'h0627, 16'h062F,
    16'h0630, 16'h0631, 16'h0632, 16'h0698, 16'h0648, 16'h0649
  };

endpackage

`default_nettype wire

// ===== rtl/pgs_classify.sv =====
// Classifies one code point: first matching form-table row, non-joining flag.
// Depends on pgs_pkg.
`default_nettype none

module pgs_classify import pgs_pkg::*; (
  input  logic [15:0] code_point_i,
  output cls_t        cls_o
);

  logic [RowW-1:0] row;
  logic            nonjoin;

  // scan from the bottom so the first matching row wins
  always_comb begin
    row = NoRow;
    for (int r = NumRows - 1; r >= 0; r--) begin
      for (int k = 0; k < NumCols; k++) begin
        if (FormTable[r][k] == code_point_i) begin
          row = RowW'(r);
        end
      end
    end
  end

  always_comb begin
    nonjoin = 1'b0;
    for (int i = 0; i < NumNonJoin; i++) begin
      if (NonJoinSet[i] == code_point_i) begin
        nonjoin = 1'b1;
      end
    end
  end

  assign cls_o.row     = row;
  assign cls_o.persian = (row != NoRow);
  assign cls_o.nonjoin = nonjoin;

endmodule

`default_nettype wire

// ===== rtl/pgs_former.sv =====
// Picks the presentation form of one character from its row and neighbors.
// Depends on pgs_pkg.
`default_nettype none

module pgs_former import pgs_pkg::*; (
  input  logic [15:0]     code_point_i,
  input  logic [RowW-1:0] row_i,
  input  logic            prev_persian_i,
  input  logic            prev_nonjoin_i,
  input  logic            next_persian_i,
  output logic [15:0]     glyph_o
);

  form_e form;

  always_comb begin
    if (prev_persian_i && next_persian_i) begin
      form = prev_nonjoin_i ? FORM_INITIAL : FORM_MEDIAL;
    end else if (next_persian_i) begin
      form = FORM_INITIAL;
    end else if (prev_persian_i) begin
      form = prev_nonjoin_i ? FORM_ISOLATED : FORM_FINAL;
    end else begin
      form = FORM_ISOLATED;
    end
  end

  always_comb begin
    glyph_o = code_point_i;
    if (row_i != NoRow) begin
      if (row_i == YehRow) begin
        glyph_o = YehSub[form];
      end else begin
        glyph_o = FormTable[row_i][form];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pgs_out_fifo.sv =====
// Four-entry result queue; takes up to two results, gives one per cycle while ready_i is high.
// Depends on pgs_pkg and the shaper assertion macros.
`default_nettype none
`include "persian_glyph_shaper_unit_macros.svh"

module pgs_out_fifo import pgs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  entry_t     wr0_i,
  input  entry_t     wr1_i,
  output logic       space2_o,
  output logic       valid_o,
  input  logic       ready_i,
  output entry_t     rd_o
);

  entry_t mem [FifoDepth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_nxt;

  assign pop        = valid_o && ready_i;
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);
  assign valid_o    = (count_q != '0);
  assign space2_o   = (count_q <= CntW'(FifoDepth - 2));
  assign rd_o       = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_ptr_q] <= wr0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_ptr_nxt] <= wr1_i;
    end
  end

  `PGS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(FifoDepth))
  `PGS_ASSERT(a_ptr_match, clk_i, rst_ni, count_q[PtrW-1:0] == PtrW'(wr_ptr_q - rd_ptr_q))
  `PGS_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_cnt_i == 2'd2 && !space2_o)

endmodule

`default_nettype wire

// ===== rtl/persian_glyph_shaper_unit.sv =====
// Top level of the contextual glyph shaper: hold stage, shaping, result queue.
// Depends on pgs_pkg, pgs_classify, pgs_former, pgs_out_fifo and the macros.
//
//   channel | handshake                 | fields                      | dir
//   --------+---------------------------+-----------------------------+-----
//   input   | in_valid_i / in_ready_o   | code_point_i, end_of_text_i | in
//   result  | out_valid_o / out_ready_i | glyph_o, last_o             | out
//
// One transaction in per cycle; its results are written to the queue at the
// accepting edge and can leave on the result port from the next cycle on.
// Each character is held until the next one arrives, so its glyph appears
// with the following transaction; end of text releases held and current.
// An end-of-text transaction with a held character yields two results, which the
// four-entry queue drains at one per cycle while out_ready_i is high; input stalls
// while the queue has fewer than two free entries. Reset empties the hold stage and queue.
`default_nettype none
`include "persian_glyph_shaper_unit_macros.svh"

module persian_glyph_shaper_unit import pgs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_point_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] glyph_o,
  output logic        last_o
);

  logic            held_valid_q, held_valid_d;
  logic            prev_p_q, prev_p_d;
  logic            prev_nj_q, prev_nj_d;
  logic [15:0]     held_char_q;
  logic [RowW-1:0] held_row_q;
  logic            held_nj_q;

  cls_t        cls_in;
  logic        in_fire;
  logic        prev_p_mid, prev_nj_mid;
  logic [15:0] glyph_held, glyph_cur;
  logic [1:0]  push_cnt;
  entry_t      wr0, wr1, rd;

  assign in_fire = in_valid_i && in_ready_o;

  pgs_classify u_classify (
    .code_point_i (code_point_i),
    .cls_o        (cls_in)
  );

  // releasing the held character makes it the preceding letter
  assign prev_p_mid  = held_valid_q ? (held_row_q != NoRow) : prev_p_q;
  assign prev_nj_mid = held_valid_q ? held_nj_q : prev_nj_q;

  pgs_former u_form_held (
    .code_point_i   (held_char_q),
    .row_i          (held_row_q),
    .prev_persian_i (prev_p_q),
    .prev_nonjoin_i (prev_nj_q),
    .next_persian_i (cls_in.persian),
    .glyph_o        (glyph_held)
  );

  pgs_former u_form_cur (
    .code_point_i   (code_point_i),
    .row_i          (cls_in.row),
    .prev_persian_i (prev_p_mid),
    .prev_nonjoin_i (prev_nj_mid),
    .next_persian_i (1'b0),
    .glyph_o        (glyph_cur)
  );

  always_comb begin
    push_cnt = 2'd0;
    if (in_fire) begin
      push_cnt = 2'({1'b0, held_valid_q} + {1'b0, end_of_text_i});
    end
    if (held_valid_q) begin
      wr0.glyph = glyph_held;
      wr0.last  = 1'b0;
    end else begin
      wr0.glyph = glyph_cur;
      wr0.last  = 1'b1;
    end
    wr1.glyph = glyph_cur;
    wr1.last  = 1'b1;
  end

  always_comb begin
    held_valid_d = held_valid_q;
    prev_p_d     = prev_p_q;
    prev_nj_d    = prev_nj_q;
    if (in_fire) begin
      if (end_of_text_i) begin
        held_valid_d = 1'b0;
        prev_p_d     = 1'b0;
        prev_nj_d    = 1'b0;
      end else begin
        held_valid_d = 1'b1;
        prev_p_d     = prev_p_mid;
        prev_nj_d    = prev_nj_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      prev_p_q     <= 1'b0;
      prev_nj_q    <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      prev_p_q     <= prev_p_d;
      prev_nj_q    <= prev_nj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !end_of_text_i) begin
      held_char_q <= code_point_i;
      held_row_q  <= cls_in.row;
      held_nj_q   <= cls_in.nonjoin;
    end
  end

  pgs_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .wr0_i      (wr0),
    .wr1_i      (wr1),
    .space2_o   (in_ready_o),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .rd_o       (rd)
  );

  assign glyph_o = rd.glyph;
  assign last_o  = rd.last;

  `PGS_ASSERT(a_eot_clears, clk_i, rst_ni, in_fire && end_of_text_i |=> !held_valid_q)
  `PGS_ASSERT(a_hold_sets, clk_i, rst_ni, in_fire && !end_of_text_i |=> held_valid_q)
  `PGS_ASSERT_NEVER(a_prev_idle, clk_i, rst_ni, !held_valid_q && (prev_p_q || prev_nj_q))

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for persian_glyph_shaper_unit: drives code point streams and checks
// each shaped glyph and last flag against a local contextual-shaping predictor.
// Depends on pgs_pkg for the result entry and form column types.
module testbench;
  import pgs_pkg::*;

  localparam int NumFormRows = 45;
  localparam int YehRowIdx   = 39;
  localparam int IdleLimit   = 3000;

  localparam logic [15:0] ShapeRows [NumFormRows][5] = '{
    '{16'h0623, 16'hFE83, 16'h0623, 16'hFE84, 16'hFE84},
    '{16'h0627, 16'hFE8D, 16'h0627, 16'hFE8E, 16'hFE8E},
    '{16'h0622, 16'hFE81, 16'h0622, 16'hFE82, 16'hFE82},
    '{16'h0621, 16'hFE80, 16'h0621, 16'h0621, 16'h0621},
    '{16'h0624, 16'hFE85, 16'h0624, 16'hFE86, 16'hFE86},
    '{16'h0625, 16'hFE87, 16'h0625, 16'hFE88, 16'hFE88},
    '{16'h0626, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A},
    '{16'h0628, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90},
    '{16'h067E, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57},
    '{16'h062A, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96},
    '{16'h0629, 16'hFE93, 16'h0629, 16'h0629, 16'hFE94},
    '{16'h062B, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A},
    '{16'h062C, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E},
    '{16'h0686, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B},
    '{16'h062D, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2},
    '{16'h062E, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6},
    '{16'h062F, 16'hFEA9, 16'h062F, 16'hFEAA, 16'hFEAA},
    '{16'h0630, 16'hFEAB, 16'h0630, 16'hFEAC, 16'hFEAC},
    '{16'h0631, 16'hFEAD, 16'h0631, 16'hFEAE, 16'hFEAE},
    '{16'h0632, 16'hFEAF, 16'h0632, 16'hFEB0, 16'hFEB0},
    '{16'h0698, 16'hFB8A, 16'h0698, 16'hFB8B, 16'hFB8B},
    '{16'h0633, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2},
    '{16'h0634, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6},
    '{16'h0635, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA},
    '{16'h0636, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE},
    '{16'h0637, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2},
    '{16'h0638, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6},
    '{16'h0639, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA},
    '{16'h063A, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE},
    '{16'h0641, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2},
    '{16'h0642, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6},
    '{16'h06A9, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
    '{16'h0643, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
    '{16'h06AF, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93},
    '{16'h0644, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE},
    '{16'h0645, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2},
    '{16'h0646, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6},
    '{16'h0647, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA},
    '{16'h0648, 16'hFEED, 16'h0648, 16'hFEEE, 16'hFEEE},
    '{16'h06CC, 16'hFBFC, 16'hFBFE, 16'hFBFF, 16'hFBFD},
    '{16'h064A, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2},
    '{16'h0649, 16'hFEEF, 16'h0649, 16'hFEF0, 16'hFEF0},
    '{16'h0640, 16'h0640, 16'h0640, 16'h0640, 16'h0640},
    '{16'hFEFB, 16'hFEFB, 16'hFEFB, 16'hFEFC, 16'hFEFC},
    '{16'hFEF7, 16'hFEF7, 16'hFEF7, 16'hFEF8, 16'hFEF8}
  };

  localparam logic [15:0] YehForms [5] = '{
    16'h06CC, 16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0
  };

  localparam logic [15:0] NonJoiners [13] = '{
    16'h0621, 16'h0622, 16'h0623, 16'h0624, 16'h0625, 16'h0627, 16'h062F,
    16'h0630, 16'h0631, 16'h0632, 16'h0698, 16'h0648, 16'h0649
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] code_point_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] glyph_o;
  logic        last_o;

  entry_t      pending_glyphs[$];
  logic [15:0] held_cp;
  logic        held_live;
  logic        prev_fa;
  logic        prev_nj;

  int mismatches;
  int idle_cycles;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_left;
  int rx_busy_left;

  persian_glyph_shaper_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_point_i  (code_point_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .glyph_o       (glyph_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int form_row(logic [15:0] cp);
    for (int r = 0; r < NumFormRows; r++) begin
      for (int k = 0; k < 5; k++) begin
        if (ShapeRows[r][k] == cp) return r;
      end
    end
    return NumFormRows;
  endfunction

  function automatic logic joins_not(logic [15:0] cp);
    foreach (NonJoiners[i]) begin
      if (NonJoiners[i] == cp) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [15:0] shape_glyph(logic [15:0] cp, logic pp, logic pnj,
                                              logic np);
    int    r;
    form_e col;
    r = form_row(cp);
    if (r == NumFormRows) return cp;
    if (pp && np) col = pnj ? FORM_INITIAL : FORM_MEDIAL;
    else if (np) col = FORM_INITIAL;
    else if (pp) col = pnj ? FORM_ISOLATED : FORM_FINAL;
    else col = FORM_ISOLATED;
    if (r == YehRowIdx) return YehForms[col];
    return ShapeRows[r][col];
  endfunction

  task automatic predict_glyphs(logic [15:0] cp, logic eot);
    if (held_live) begin
      pending_glyphs.push_back('{glyph: shape_glyph(held_cp, prev_fa, prev_nj,
                                                    form_row(cp) != NumFormRows),
                                 last: 1'b0});
      prev_fa = form_row(held_cp) != NumFormRows;
      prev_nj = joins_not(held_cp);
    end
    if (eot) begin
      pending_glyphs.push_back('{glyph: shape_glyph(cp, prev_fa, prev_nj, 1'b0),
                                 last: 1'b1});
      held_cp   = '0;
      held_live = 1'b0;
      prev_fa   = 1'b0;
      prev_nj   = 1'b0;
    end else begin
      held_cp   = cp;
      held_live = 1'b1;
    end
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_char(logic [15:0] cp, logic eot);
    int gap;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    code_point_i  <= cp;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_glyphs(cp, eot);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = rand_gap();
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 72) return ShapeRows[$urandom_range(0, NumFormRows - 1)][$urandom_range(0, 4)];
    if (sel < 80) return 16'h0020;
    if (sel < 90) return 16'($urandom_range(16'h0600, 16'h06FF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // runs of shaped text ended by end of text, with some raw noise between
  task automatic send_text(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_char(pick_char(), i == len - 1);
        sent += len;
      end
    end
  endtask

  task automatic test_directed_cases();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_char(16'h0000, 1'b1);
    send_char(16'h06CC, 1'b1);
    send_char(16'h0628, 1'b0);
    send_char(16'h06CC, 1'b0);
    send_char(16'h0628, 1'b0);
    send_char(16'h06CC, 1'b0);
    send_char(16'h0020, 1'b0);
    send_char(16'h0627, 1'b0);
    send_char(16'h06CC, 1'b0);
    send_char(16'h0644, 1'b0);
    send_char(16'h0648, 1'b0);
    send_char(16'h06CC, 1'b0);
    send_char(16'h0633, 1'b1);
    send_char(16'hFED9, 1'b0);
    send_char(16'hFEDB, 1'b0);
    send_char(16'hFE91, 1'b0);
    send_char(16'h0640, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0621, 1'b0);
    send_char(16'hFEFB, 1'b1);
    send_char(16'h0041, 1'b1);
    send_char(16'h0627, 1'b0);
    send_char(16'h06CC, 1'b1);
    send_char(16'h06CC, 1'b0);
    send_char(16'h06CC, 1'b1);
  endtask

  task automatic test_streaming_no_idle();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_text(300);
  endtask

  task automatic test_random_gaps();
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    send_text(500);
  endtask

  task automatic test_receiver_stalls();
    tx_idle_pct  = 0;
    rx_stall_pct = 50;
    send_text(300);
  endtask

  task automatic test_sender_gaps();
    tx_idle_pct  = 50;
    rx_stall_pct = 0;
    send_text(300);
  endtask

  // output held off while end-of-text items keep the queue filling
  task automatic test_backpressure_fill();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 300;
    for (int i = 0; i < 60; i++) send_char(pick_char(), $urandom_range(0, 2) == 0);
  endtask

  task automatic test_drain_pause();
    tx_idle_pct  = 10;
    rx_stall_pct = 30;
    for (int i = 0; i < 4; i++) begin
      send_text(50);
      wait_drained();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    code_point_i  = '0;
    end_of_text_i = 1'b0;
    held_cp       = '0;
    held_live     = 1'b0;
    prev_fa       = 1'b0;
    prev_nj       = 1'b0;
    mismatches    = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    rx_hold_left  = 0;
    rx_busy_left  = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_streaming_no_idle();
    test_random_gaps();
    test_receiver_stalls();
    test_sender_gaps();
    test_backpressure_fill();
    test_drain_pause();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else if (rx_busy_left > 0) begin
        out_ready_i <= 1'b0;
        rx_busy_left--;
      end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready_i  <= 1'b0;
        rx_busy_left = rand_gap() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    entry_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_glyphs.size() == 0) begin
        note_mismatch("unexpected transaction, glyph", 16'h0000, glyph_o);
      end else begin
        want = pending_glyphs.pop_front();
        if (want.glyph !== glyph_o) note_mismatch("glyph", want.glyph, glyph_o);
        if (want.last !== last_o) note_mismatch("last", 16'(want.last), 16'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
